/* rtl/pbra_pkg.sv */
package pbra_pkg;

   // opcodes of the request channel
   localparam logic [2:0] OPC_RELOAD = 3'd0;
   localparam logic [2:0] OPC_BEGIN  = 3'd1;
   localparam logic [2:0] OPC_BAR    = 3'd2;
   localparam logic [2:0] OPC_ROM    = 3'd3;
   localparam logic [2:0] OPC_END    = 3'd4;

   // result kinds
   localparam logic [1:0] RK_BAR = 2'd0;
   localparam logic [1:0] RK_ROM = 2'd1;
   localparam logic [1:0] RK_CMD = 2'd2;

   // register indexes and port widths
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_IO_START  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_START = 1'b1;

   localparam int IO_START_W = 16;
   localparam int MEM_START_W = 32;
   localparam logic [IO_START_W-1:0] IO_POOL_RESET = 16'h8000;

   localparam int IO_SIZE_W = 16;
   localparam int CMD_W = 16;
   localparam int VALUE_W = 32;

   localparam logic [CMD_W-1:0] CMD_EN_CLEAR = 16'hfff8;
   localparam logic [CMD_W-1:0] CMD_IO_EN    = 16'h0001;
   localparam logic [CMD_W-1:0] CMD_MEM_EN   = 16'h0002;
   localparam logic [7:0] HDR_TYPE_MASK = 8'h7f;

   // base classes that force I/O enable
   localparam logic [7:0] BCLASS_LEGACY  = 8'h00;
   localparam logic [7:0] BCLASS_STORAGE = 8'h01;
   localparam logic [7:0] BCLASS_DISPLAY = 8'h03;

   typedef enum logic [2:0] {
      W_NOP,
      W_RELOAD,
      W_BEGIN,
      W_IO,
      W_MEM,
      W_ROM,
      W_END
   } work_kind_type;

   typedef struct packed {
      work_kind_type    kind;
      logic [CMD_W-1:0] cmd;
      logic             type_zero;
   } work_ctrl_type;

endpackage

/* rtl/pbra_if.sv */
interface pbra_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [7:0]  header_type;
   logic [15:0] command_in;
   logic [7:0]  base_class;
   logic [31:0] readback;

   modport source (output valid, opcode, header_type, command_in, base_class, readback,
                   input ready);
   modport sink (input valid, opcode, header_type, command_in, base_class, readback,
                 output ready);
endinterface

interface pbra_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] value;

   modport source (output valid, result_kind, value, input ready);
   modport sink (input valid, result_kind, value, output ready);
endinterface

/* rtl/pci_bar_resource_allocator.sv */
// PCI BAR sizing and bump allocator.
// req_bus carries one opcode item per transfer: reload pools, begin device,
// BAR readback, ROM readback, end device. rsp_bus returns at most one result
// per item: a BAR base (kind 0), a ROM base (kind 1) or the device's final
// command word (kind 2). csr_* writes the two pool start registers; write them
// only while nothing is in flight.
// An item is decoded and its size worked out in the front stage, waits in a
// two-entry queue, then updates the pool pointers in the back stage, whose
// round-up and bump form the loop that sets the rate. Each item is registered
// in the front stage, the queue and the back stage before its result is valid.
// Throughput: one item per cycle while rsp_bus is ready.
// Reset loads the pool registers with 0x8000 (I/O) and 0 (memory), points the
// pools there and clears the command word and header state.
// If rsp_bus stalls, the held result stays put, the queue fills, and req_bus
// ready drops once the front stage cannot move; items with no result keep
// passing the back stage while a result is held.
module pci_bar_resource_allocator import pbra_pkg::*; #(
   parameter int ADDR_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   pbra_req_if.sink              req_bus,
   pbra_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CTRL_W = $bits(work_ctrl_type);
   localparam int WORK_W = CTRL_W + 2 * ADDR_WIDTH;

   logic                  front_vld, front_rdy;
   work_ctrl_type         front_ctrl;
   logic [ADDR_WIDTH-1:0] front_size, front_m1;

   logic                  back_vld, back_rdy;
   work_ctrl_type         back_ctrl;
   logic [ADDR_WIDTH-1:0] back_size, back_m1;

   logic [WORK_W-1:0]     q_push_data, q_pop_data;

   pbra_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .work_vld     (front_vld),
      .work_rdy     (front_rdy),
      .work_ctrl    (front_ctrl),
      .work_size    (front_size),
      .work_size_m1 (front_m1)
   );

   assign q_push_data = {front_ctrl, front_size, front_m1};

   pbra_queue #(.WIDTH(WORK_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (front_vld),
      .push_rdy  (front_rdy),
      .push_data (q_push_data),
      .pop_vld   (back_vld),
      .pop_rdy   (back_rdy),
      .pop_data  (q_pop_data)
   );

   assign back_ctrl = work_ctrl_type'(q_pop_data[WORK_W-1 -: CTRL_W]);
   assign back_size = q_pop_data[2*ADDR_WIDTH-1 -: ADDR_WIDTH];
   assign back_m1 = q_pop_data[ADDR_WIDTH-1:0];

   pbra_back #(.ADDR_WIDTH(ADDR_WIDTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .work_vld     (back_vld),
      .work_rdy     (back_rdy),
      .work_ctrl    (back_ctrl),
      .work_size    (back_size),
      .work_size_m1 (back_m1),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_bus      (rsp_bus)
   );

endmodule

/* rtl/pbra_front.sv */
module pbra_front import pbra_pkg::*; #(
   parameter int ADDR_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   pbra_req_if.sink              req_bus,
   output logic                  work_vld,
   input  logic                  work_rdy,
   output work_ctrl_type         work_ctrl,
   output logic [ADDR_WIDTH-1:0] work_size,
   output logic [ADDR_WIDTH-1:0] work_size_m1
);

   logic                  stage_vld_ff, stage_vld_in;
   work_ctrl_type         ctrl_ff, ctrl_in;
   logic [ADDR_WIDTH-1:0] size_ff, size_in;
   logic [ADDR_WIDTH-1:0] m1_ff, m1_in;

   logic                  accept;
   logic                  class_io;
   logic [ADDR_WIDTH-1:0] rb_ext;
   logic [ADDR_WIDTH-1:0] masked;
   logic [ADDR_WIDTH-1:0] neg;
   logic [IO_SIZE_W-1:0]  io_m1;

   assign req_bus.ready = !stage_vld_ff || work_rdy;
   assign accept = req_bus.valid && req_bus.ready;
   assign rb_ext = ADDR_WIDTH'(req_bus.readback);
   assign class_io = (req_bus.base_class == BCLASS_LEGACY) ||
                     (req_bus.base_class == BCLASS_STORAGE) ||
                     (req_bus.base_class == BCLASS_DISPLAY);

   always_comb begin
      ctrl_in.kind = W_NOP;
      ctrl_in.cmd = req_bus.command_in & CMD_EN_CLEAR;
      ctrl_in.type_zero = (req_bus.header_type & HDR_TYPE_MASK) == 8'd0;
      if (ctrl_in.type_zero && class_io) begin
         ctrl_in.cmd = ctrl_in.cmd | CMD_IO_EN;
      end
      unique case (req_bus.opcode)
         OPC_RELOAD: ctrl_in.kind = W_RELOAD;
         OPC_BEGIN:  ctrl_in.kind = W_BEGIN;
         OPC_BAR: begin
            if (req_bus.readback == '0) begin
               ctrl_in.kind = W_NOP;
            end else if (req_bus.readback[0]) begin
               ctrl_in.kind = W_IO;
            end else begin
               ctrl_in.kind = W_MEM;
            end
         end
         OPC_ROM:    ctrl_in.kind = (req_bus.readback == '0) ? W_NOP : W_ROM;
         OPC_END:    ctrl_in.kind = W_END;
         default:    ctrl_in.kind = W_NOP;
      endcase
   end

   // size is the two's complement of the readback with its flag bits dropped;
   // size - 1 is then simply the inverse, except for an I/O size that wraps to zero
   always_comb begin
      case (ctrl_in.kind)
         W_IO:    masked = {rb_ext[ADDR_WIDTH-1:2], 2'b00};
         W_ROM:   masked = {rb_ext[ADDR_WIDTH-1:1], 1'b0};
         default: masked = {rb_ext[ADDR_WIDTH-1:4], 4'b0000};
      endcase
      neg = '0 - masked;
      io_m1 = ~masked[IO_SIZE_W-1:0];
      if (ctrl_in.kind == W_IO) begin
         size_in = ADDR_WIDTH'(neg[IO_SIZE_W-1:0]);
         m1_in = (masked[IO_SIZE_W-1:0] == '0) ? '1 : ADDR_WIDTH'(io_m1);
      end else begin
         size_in = neg;
         m1_in = ~masked;
      end
   end

   always_comb begin
      if (accept && ctrl_in.kind != W_NOP) begin
         stage_vld_in = 1'b1;
      end else if (work_rdy) begin
         stage_vld_in = 1'b0;
      end else begin
         stage_vld_in = stage_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff <= ctrl_in;
         size_ff <= size_in;
         m1_ff <= m1_in;
      end
   end

   assign work_vld = stage_vld_ff;
   assign work_ctrl = ctrl_ff;
   assign work_size = size_ff;
   assign work_size_m1 = m1_ff;

   // items that do nothing never reach the queue
   a_nop_dropped: assert property (@(posedge clock) disable iff (reset)
      accept && ctrl_in.kind == W_NOP |=> !stage_vld_ff)
      else $error("no-op item was staged");

endmodule

/* rtl/pbra_queue.sv */
module pbra_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_vld,
   output logic             push_rdy,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_vld,
   input  logic             pop_rdy,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_rdy = count_ff != CNT_W'(DEPTH);
   assign pop_vld = count_ff != '0;
   assign push = push_vld && push_rdy;
   assign pop = pop_vld && pop_rdy;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fill: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count lost a pop");

endmodule

/* rtl/pbra_back.sv */
module pbra_back import pbra_pkg::*; #(
   parameter int ADDR_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  work_vld,
   output logic                  work_rdy,
   input  work_ctrl_type         work_ctrl,
   input  logic [ADDR_WIDTH-1:0] work_size,
   input  logic [ADDR_WIDTH-1:0] work_size_m1,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   pbra_rsp_if.source            rsp_bus
);

   logic [IO_START_W-1:0]  io_start_ff;
   logic [MEM_START_W-1:0] mem_start_ff;

   logic [ADDR_WIDTH-1:0]  io_ptr_ff, io_ptr_in;
   logic [ADDR_WIDTH-1:0]  mem_ptr_ff, mem_ptr_in;
   logic [CMD_W-1:0]       cmd_acc_ff, cmd_acc_in;
   logic                   type_zero_ff, type_zero_in;

   logic                   rsp_vld_ff, rsp_vld_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;

   logic                   is_alloc, makes_rsp, pop;
   logic [ADDR_WIDTH-1:0]  ptr_sel, rounded, bumped;

   assign is_alloc = (work_ctrl.kind == W_IO) || (work_ctrl.kind == W_MEM) ||
                     (work_ctrl.kind == W_ROM);
   assign makes_rsp = (work_ctrl.kind == W_END) || (is_alloc && type_zero_ff);
   // a result-less item never waits on the output side
   assign work_rdy = !makes_rsp || !rsp_vld_ff || rsp_bus.ready;
   assign pop = work_vld && work_rdy;

   // round the pool pointer up to the size, then bump past the block
   assign ptr_sel = (work_ctrl.kind == W_IO) ? io_ptr_ff : mem_ptr_ff;
   assign rounded = (ptr_sel + work_size_m1) & ~work_size_m1;
   assign bumped = rounded + work_size;

   always_comb begin
      io_ptr_in = io_ptr_ff;
      mem_ptr_in = mem_ptr_ff;
      cmd_acc_in = cmd_acc_ff;
      type_zero_in = type_zero_ff;
      if (pop) begin
         case (work_ctrl.kind)
            W_RELOAD: begin
               io_ptr_in = ADDR_WIDTH'(io_start_ff);
               mem_ptr_in = ADDR_WIDTH'(mem_start_ff);
            end
            W_BEGIN: begin
               cmd_acc_in = work_ctrl.cmd;
               type_zero_in = work_ctrl.type_zero;
            end
            W_IO: begin
               if (type_zero_ff) begin
                  io_ptr_in = bumped;
                  cmd_acc_in = cmd_acc_ff | CMD_IO_EN;
               end
            end
            W_MEM, W_ROM: begin
               if (type_zero_ff) begin
                  mem_ptr_in = bumped;
                  cmd_acc_in = cmd_acc_ff | CMD_MEM_EN;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (work_ctrl.kind)
         W_IO: begin
            rsp_kind_in = RK_BAR;
            rsp_value_in = VALUE_W'(rounded) | VALUE_W'(1);
         end
         W_ROM: begin
            rsp_kind_in = RK_ROM;
            rsp_value_in = VALUE_W'(rounded) | VALUE_W'(1);
         end
         W_END: begin
            rsp_kind_in = RK_CMD;
            rsp_value_in = VALUE_W'(cmd_acc_ff);
         end
         default: begin
            rsp_kind_in = RK_BAR;
            rsp_value_in = VALUE_W'(rounded);
         end
      endcase
      if (pop && makes_rsp) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         io_start_ff <= IO_POOL_RESET;
         mem_start_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IO_START:  io_start_ff <= csr_wdata[IO_START_W-1:0];
            CSR_MEM_START: mem_start_ff <= csr_wdata[MEM_START_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         io_ptr_ff <= ADDR_WIDTH'(IO_POOL_RESET);
         mem_ptr_ff <= '0;
         cmd_acc_ff <= '0;
         type_zero_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         io_ptr_ff <= io_ptr_in;
         mem_ptr_ff <= mem_ptr_in;
         cmd_acc_ff <= cmd_acc_in;
         type_zero_ff <= type_zero_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && makes_rsp) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_bus.valid = rsp_vld_ff;
   assign rsp_bus.result_kind = rsp_kind_ff;
   assign rsp_bus.value = rsp_value_ff;

   a_end_gives_cmd: assert property (@(posedge clock) disable iff (reset)
      pop && work_ctrl.kind == W_END |=> rsp_bus.valid && rsp_bus.result_kind == RK_CMD)
      else $error("end of device gave no command word");

   a_reload: assert property (@(posedge clock) disable iff (reset)
      pop && work_ctrl.kind == W_RELOAD |=> io_ptr_ff == ADDR_WIDTH'($past(io_start_ff)))
      else $error("I/O pool not reloaded");

endmodule

/* tb/sv/tb_pci_bar_resource_allocator.sv */
`timescale 1ns / 1ps

module tb_pci_bar_resource_allocator;
   import pbra_pkg::*;

   localparam int ADDR_W = 32;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 105;
   localparam int NUM_PHASES = 6;

   // opcodes the block ignores
   localparam logic [2:0] OPC_RSVD5 = 3'd5;
   localparam logic [2:0] OPC_RSVD7 = 3'd7;

   typedef struct {
      logic [2:0]  opcode;
      logic [7:0]  header_type;
      logic [15:0] command_in;
      logic [7:0]  base_class;
      logic [31:0] readback;
   } req_item_type;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] value;
   } result_type;

   typedef struct {
      req_item_type item;
      bit           typed;
      result_type   res;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pbra_req_if req_bus ();
   pbra_rsp_if rsp_bus ();

   pci_bar_resource_allocator #(.ADDR_WIDTH(ADDR_W)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // allocator state as the testbench sees it
   logic [15:0]       io_start;
   logic [31:0]       mem_start;
   logic [ADDR_W-1:0] io_ptr;
   logic [ADDR_W-1:0] mem_ptr;
   logic [15:0]       cmd_acc;
   bit                hdr_type0;

   result_type  pending_results[$];
   dir_row_type dir_tab[$];
   int          err_count;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic req_item_type mk_item(logic [2:0] op, logic [7:0] hdr, logic [15:0] cmd,
                                            logic [7:0] cls, logic [31:0] rb);
      req_item_type it;
      it.opcode = op;
      it.header_type = hdr;
      it.command_in = cmd;
      it.base_class = cls;
      it.readback = rb;
      return it;
   endfunction

   // round the pointer up to a multiple of size, hand out that base, move past it
   task automatic bump(inout logic [ADDR_W-1:0] ptr, input logic [ADDR_W-1:0] size,
                       output logic [ADDR_W-1:0] base);
      logic [ADDR_W-1:0] p;
      p = (ptr + size - 1'b1) & ~(size - 1'b1);
      base = p;
      ptr = p + size;
   endtask

   task automatic alloc_step(input req_item_type it, output bit produced,
                             output result_type res);
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] base;
      logic [31:0]       neg_rb;
      produced = 1'b0;
      res.kind = '0;
      res.value = '0;
      case (it.opcode)
         OPC_RELOAD: begin
            io_ptr = {16'h0, io_start};
            mem_ptr = mem_start;
         end
         OPC_BEGIN: begin
            cmd_acc = it.command_in & CMD_EN_CLEAR;
            hdr_type0 = ((it.header_type & HDR_TYPE_MASK) == 8'h00);
            if (hdr_type0 && (it.base_class == BCLASS_LEGACY || it.base_class == BCLASS_STORAGE
                              || it.base_class == BCLASS_DISPLAY))
               cmd_acc = cmd_acc | CMD_IO_EN;
         end
         OPC_BAR: begin
            if (hdr_type0 && it.readback != 32'h0) begin
               if (it.readback[0]) begin
                  neg_rb = 32'h0 - (it.readback & ~32'h3);
                  size = {16'h0, neg_rb[15:0]};
                  bump(io_ptr, size, base);
                  base[0] = 1'b1;
                  cmd_acc = cmd_acc | CMD_IO_EN;
               end else begin
                  size = 32'h0 - (it.readback & ~32'hf);
                  bump(mem_ptr, size, base);
                  cmd_acc = cmd_acc | CMD_MEM_EN;
               end
               produced = 1'b1;
               res.kind = RK_BAR;
               res.value = base;
            end
         end
         OPC_ROM: begin
            if (hdr_type0 && it.readback != 32'h0) begin
               size = 32'h0 - (it.readback & ~32'h1);
               bump(mem_ptr, size, base);
               base[0] = 1'b1;
               cmd_acc = cmd_acc | CMD_MEM_EN;
               produced = 1'b1;
               res.kind = RK_ROM;
               res.value = base;
            end
         end
         OPC_END: begin
            produced = 1'b1;
            res.kind = RK_CMD;
            res.value = {16'h0, cmd_acc};
         end
         default: ;
      endcase
   endtask

   task automatic add_row(logic [2:0] op, logic [7:0] hdr, logic [15:0] cmd, logic [7:0] cls,
                          logic [31:0] rb, bit typed, logic [1:0] kind, logic [31:0] value);
      dir_row_type row;
      row.item = mk_item(op, hdr, cmd, cls, rb);
      row.typed = typed;
      row.res.kind = kind;
      row.res.value = value;
      dir_tab.push_back(row);
   endtask

   // called and returns just after a falling edge
   task automatic send_item(input req_item_type it, input bit typed,
                            input result_type typed_res);
      bit         produced;
      result_type got;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= it.opcode;
      req_bus.header_type <= it.header_type;
      req_bus.command_in <= it.command_in;
      req_bus.base_class <= it.base_class;
      req_bus.readback <= it.readback;
      do @(posedge clock); while (!req_bus.ready);
      alloc_step(it, produced, got);
      if (typed)
         pending_results.push_back(typed_res);
      else if (produced)
         pending_results.push_back(got);
      @(negedge clock);
   endtask

   function automatic logic [31:0] bar_readback();
      int unsigned pick;
      int unsigned k;
      logic [31:0] rb;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         k = $urandom_range(2, 8);
         rb = (32'hffff_ffff << k) | 32'h1;
         rb[1] = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1))
            rb[31:16] = 16'h0;
      end else if (pick < 90) begin
         // mostly modest windows, now and then a huge one
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 31) : $urandom_range(4, 20);
         rb = 32'hffff_ffff << k;
         rb[3:1] = 3'($urandom_range(0, 7));
      end else if (pick < 95) begin
         rb = $urandom;
      end else begin
         rb = 32'h0;
      end
      return rb;
   endfunction

   function automatic logic [31:0] rom_readback();
      int unsigned pick;
      logic [31:0] rb;
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
         rb = 32'hffff_ffff << $urandom_range(11, 24);
         rb[0] = 1'($urandom_range(0, 1));
      end else if (pick < 95) begin
         rb = $urandom;
      end else begin
         rb = 32'h0;
      end
      return rb;
   endfunction

   task automatic send_random(input int n);
      int          sent;
      int unsigned pick;
      int          nbars;
      logic [7:0]  hdr;
      logic [7:0]  cls;
      result_type  none;
      none.kind = '0;
      none.value = '0;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            pick = $urandom_range(0, 99);
            hdr = (pick < 45) ? 8'h00 : (pick < 80) ? 8'h80 : 8'($urandom);
            cls = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_item(mk_item(OPC_BEGIN, hdr, 16'($urandom), cls, $urandom), 1'b0, none);
            nbars = $urandom_range(0, 6);
            for (int i = 0; i < nbars; i++)
               send_item(mk_item(OPC_BAR, 8'($urandom), 16'($urandom), 8'($urandom),
                                 bar_readback()), 1'b0, none);
            if ($urandom_range(0, 1))
               send_item(mk_item(OPC_ROM, 8'($urandom), 16'($urandom), 8'($urandom),
                                 rom_readback()), 1'b0, none);
            send_item(mk_item(OPC_END, 8'($urandom), 16'($urandom), 8'($urandom), $urandom),
                      1'b0, none);
            sent += nbars + 3;
         end else if (pick < 83) begin
            send_item(mk_item(OPC_RELOAD, 8'($urandom), 16'($urandom), 8'($urandom),
                              $urandom), 1'b0, none);
            sent++;
         end else begin
            send_item(mk_item(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom),
                              8'($urandom), $urandom), 1'b0, none);
            sent++;
         end
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_pools(input logic [31:0] io_word, input logic [31:0] mem_word);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IO_START;
      csr_wdata <= io_word;
      @(negedge clock);
      io_start = io_word[15:0];
      csr_index <= CSR_MEM_START;
      csr_wdata <= mem_word;
      @(negedge clock);
      mem_start = mem_word;
      csr_wr_en <= 1'b0;
   endtask

   // result side: ready drawn at random, or held low for a long stretch on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transfer: result_kind %0d value %h",
                   rsp_bus.result_kind, rsp_bus.value);
            err_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.result_kind !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_bus.result_kind);
               err_count++;
            end
            if (rsp_bus.value !== want.value) begin
               $error("value: expected %h, got %h", want.value, rsp_bus.value);
               err_count++;
            end
         end
      end
   end

   initial begin : main
      logic [31:0] io_word;
      logic [31:0] mem_word;
      result_type  none;
      none.kind = '0;
      none.value = '0;
      err_count = 0;
      hold_left = 0;
      req_idle_pct = 31;
      rsp_idle_pct = 51;
      io_start = IO_POOL_RESET;
      mem_start = 32'h0;
      io_ptr = {16'h0, IO_POOL_RESET};
      mem_ptr = '0;
      cmd_acc = '0;
      hdr_type0 = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_IO_START;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OPC_RELOAD;
      req_bus.header_type = '0;
      req_bus.command_in = '0;
      req_bus.base_class = '0;
      req_bus.readback = '0;

      // directed part, pools still at their reset values
      add_row(OPC_END,    8'h00, 16'h0000, 8'h00, 32'h0000_0000, 1, RK_CMD, 32'h0000_0000);
      // readbacks before any device header are dropped
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'hffff_ff01, 0, RK_BAR, 32'h0);
      add_row(OPC_BEGIN,  8'h00, 16'hffff, 8'h03, 32'h0000_0000, 0, RK_BAR, 32'h0);
      add_row(OPC_END,    8'h00, 16'h0000, 8'h00, 32'h0000_0000, 1, RK_CMD, 32'h0000_fff9);
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'hffff_ff01, 1, RK_BAR, 32'h0000_8001);
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'hffff_fff0, 1, RK_BAR, 32'h0000_0000);
      add_row(OPC_ROM,    8'h00, 16'h0000, 8'h00, 32'hffff_f800, 1, RK_ROM, 32'h0000_0801);
      // zero readback: unimplemented BAR, nothing moves
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'h0000_0000, 0, RK_BAR, 32'h0);
      add_row(OPC_ROM,    8'h00, 16'h0000, 8'h00, 32'h0000_0000, 0, RK_BAR, 32'h0);
      add_row(OPC_END,    8'h00, 16'h0000, 8'h00, 32'h0000_0000, 1, RK_CMD, 32'h0000_fffb);
      add_row(OPC_BEGIN,  8'h80, 16'h0007, 8'h01, 32'h0000_0000, 0, RK_BAR, 32'h0);
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'hffff_ffff, 0, RK_BAR, 32'h0);
      // sizes of zero, extreme sizes and sizes that are not a power of two
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'h0000_0001, 0, RK_BAR, 32'h0);
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'h8000_0000, 0, RK_BAR, 32'h0);
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'h0000_000e, 0, RK_BAR, 32'h0);
      add_row(OPC_ROM,    8'h00, 16'h0000, 8'h00, 32'hffff_ffff, 0, RK_BAR, 32'h0);
      add_row(OPC_ROM,    8'h00, 16'h0000, 8'h00, 32'h1234_5678, 0, RK_BAR, 32'h0);
      add_row(OPC_END,    8'h00, 16'h0000, 8'h00, 32'h0000_0000, 0, RK_BAR, 32'h0);
      // header not type zero: readbacks ignored, no forced I/O enable
      add_row(OPC_BEGIN,  8'h7f, 16'haaaa, 8'h00, 32'h0000_0000, 0, RK_BAR, 32'h0);
      add_row(OPC_BAR,    8'h00, 16'h0000, 8'h00, 32'hffff_ff01, 0, RK_BAR, 32'h0);
      add_row(OPC_END,    8'h00, 16'h0000, 8'h00, 32'h0000_0000, 0, RK_BAR, 32'h0);
      add_row(OPC_RSVD5,  8'hff, 16'hffff, 8'hff, 32'hffff_ffff, 0, RK_BAR, 32'h0);
      add_row(OPC_RSVD7,  8'hff, 16'hffff, 8'hff, 32'hffff_ffff, 0, RK_BAR, 32'h0);
      add_row(OPC_RELOAD, 8'hff, 16'hffff, 8'hff, 32'hffff_ffff, 0, RK_BAR, 32'h0);
      add_row(OPC_BEGIN,  8'hff, 16'h5555, 8'hff, 32'hffff_ffff, 0, RK_BAR, 32'h0);
      add_row(OPC_END,    8'hff, 16'hffff, 8'hff, 32'hffff_ffff, 0, RK_BAR, 32'h0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i])
         send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         // junk above bit 15 of the I/O word must be dropped
         case (ph)
            0: begin io_word = 32'hffff_0000;                  mem_word = 32'h0000_0000; end
            1: begin io_word = 32'h0000_ffff;                  mem_word = 32'hffff_ffff; end
            3: begin io_word = {16'($urandom), 16'h8000};      mem_word = 32'h8000_0000; end
            5: begin io_word = 32'h0000_ffff;                  mem_word = 32'h0000_0000; end
            default: begin io_word = $urandom;                 mem_word = $urandom; end
         endcase
         write_pools(io_word, mem_word);
         if (ph < 2) begin
            req_idle_pct = 31;
            rsp_idle_pct = 51;
         end else if (ph < 4) begin
            req_idle_pct = 51;
            rsp_idle_pct = 31;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // long result stall while requests keep coming: the queue must fill
         if (ph == 4)
            hold_left = HOLD_CYCLES;
         send_item(mk_item(OPC_RELOAD, 8'($urandom), 16'($urandom), 8'($urandom), $urandom),
                   1'b0, none);
         send_random(PHASE_ITEMS);
      end

      drain();
      if (err_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
